/* hdl/soft_noise_gate_assert.svh */
// ----------------------------------------------------------------------------
// Soft noise gate assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low. The bodies are
// empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SOFT_NOISE_GATE_ASSERT_SVH
`define SOFT_NOISE_GATE_ASSERT_SVH

`ifndef SYNTHESIS
`define SNG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("soft_noise_gate: check failed");
`define SNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("soft_noise_gate: check failed");
`else
`define SNG_ASSERT_IMP(lbl, ante, cons)
`define SNG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/snga_pkg.sv */
// ----------------------------------------------------------------------------
// Soft noise gate package
// Widths, fixed-point constants, register codes and controller commands.
// ----------------------------------------------------------------------------
package snga_pkg;

  localparam int MaxChannels = 8;
  localparam int SampleBits  = 24;
  localparam int RegBits     = 24;
  localparam int CountBits   = 4;
  localparam int CfgIdxBits  = 3;
  localparam int GainFrac    = 23;
  localparam int CoeffFrac   = 24;
  localparam int RatioFrac   = 20;

  localparam int ChIdxBits   = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int SumBits     = SampleBits + ChIdxBits;
  localparam int WideBits    = (SampleBits > RegBits) ? SampleBits : RegBits;
  localparam int DivBits     = 2 * WideBits;
  localparam int LoopBits    = $clog2(WideBits + 1);
  localparam int MulABits    = WideBits + 1;
  localparam int MulBBits    = RegBits + 1;
  localparam int ProdBits    = MulABits + MulBBits;
  localparam int NumBits     = ProdBits + 1;
  localparam int GainNumBits = RegBits + RatioFrac;
  localparam int GainShift   = GainFrac - RatioFrac;

  localparam logic [RegBits-1:0]   GainUnity   = RegBits'(1 << GainFrac);
  localparam logic [RegBits-1:0]   GainMax     = '1;
  localparam logic [RegBits-1:0]   RatioUnity  = RegBits'(1 << RatioFrac);
  localparam logic [CountBits-1:0] ActiveReset = CountBits'(2);
  localparam logic [ProdBits-1:0]  RndBias     = ProdBits'((1 << GainFrac) - 1);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ACTIVE  = 3'd0,
    CFG_THRESH  = 3'd1,
    CFG_RATIO   = 3'd2,
    CFG_ATTACK  = 3'd3,
    CFG_RELEASE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_ENV,
    MUL_NUM,
    MUL_APP
  } mul_op_e;

  typedef struct packed {
    logic                 load;
    logic                 acc_en;
    logic                 div_mean;
    logic                 div_step;
    logic                 mul_en;
    mul_op_e              mul_op;
    logic                 env_upd;
    logic                 gain_eval;
    logic                 gain_take;
    logic                 app_wr;
    logic [ChIdxBits-1:0] rd_idx;
    logic [ChIdxBits-1:0] wr_idx;
    logic                 out_load;
  } snga_cmd_t;

  typedef struct packed {
    logic need_div;
  } snga_sts_t;

endpackage

/* hdl/snga_if.sv */
// ----------------------------------------------------------------------------
// Soft noise gate channels
// Frame input and gated frame output, valid/ready handshake.
// ----------------------------------------------------------------------------
interface snga_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [snga_pkg::SampleBits-1:0] sample_0;
  logic signed [snga_pkg::SampleBits-1:0] sample_1;
  logic signed [snga_pkg::SampleBits-1:0] sample_2;
  logic signed [snga_pkg::SampleBits-1:0] sample_3;
  logic signed [snga_pkg::SampleBits-1:0] sample_4;
  logic signed [snga_pkg::SampleBits-1:0] sample_5;
  logic signed [snga_pkg::SampleBits-1:0] sample_6;
  logic signed [snga_pkg::SampleBits-1:0] sample_7;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

interface snga_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_0;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_1;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_2;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_3;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_4;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_5;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_6;
  logic signed [snga_pkg::SampleBits-1:0] out_sample_7;
  logic        [snga_pkg::RegBits-1:0]    applied_gain;
  logic                                  gate_active;

  modport source (
    output valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
           out_sample_4, out_sample_5, out_sample_6, out_sample_7,
           applied_gain, gate_active,
    input  ready
  );
  modport sink (
    input  valid, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
           out_sample_4, out_sample_5, out_sample_6, out_sample_7,
           applied_gain, gate_active,
    output ready
  );
endinterface

/* hdl/soft_noise_gate.sv */
// ----------------------------------------------------------------------------
// Soft noise gate
// Downward-expander gate on one multichannel frame per handshake.
// ----------------------------------------------------------------------------
// Usage:
//   frame_i carries one word of eight signed Q1.23 samples; frame_o returns
//   the gated samples, the gain used (unsigned Q1.23) and the gate flag.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no frame is in flight: 0 channel count, 1 threshold, 2 ratio,
//   3 attack, 4 release.
//   Latency from accept to frame_o.valid is longer when the gain divide runs
//   than when the gate is open or the gain is settled without a divide. A
//   new frame is accepted in the cycle after the result is handed to the
//   output register, so each frame is finished before the next is taken; the
//   frame time is set by the shared 24-step divider (mean, then gain) and the
//   one-channel-per-cycle sum and apply passes, the apply through one multiplier.
//   Reset clears the envelope to zero and loads the register defaults; the
//   block is ready in the first cycle after reset.
//   A finished result waits in the output register while frame_o.ready is
//   low; the next frame is still accepted and processed, and holds before
//   its own output load until the waiting result is taken.
// ----------------------------------------------------------------------------
module soft_noise_gate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [snga_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [snga_pkg::RegBits-1:0]    cfg_data_i,
  snga_in_if.sink                         frame_i,
  snga_out_if.source                      frame_o
);

  snga_pkg::snga_cmd_t cmd;
  snga_pkg::snga_sts_t sts;

  logic signed [snga_pkg::SampleBits-1:0] in_sample [snga_pkg::MaxChannels];
  logic signed [snga_pkg::SampleBits-1:0] out_sample [snga_pkg::MaxChannels];
  logic        [snga_pkg::RegBits-1:0]    applied_gain;
  logic                                   gate_active;
  logic                                   in_ready;
  logic                                   out_valid;

  assign in_sample[0] = frame_i.sample_0;
  assign in_sample[1] = frame_i.sample_1;
  assign in_sample[2] = frame_i.sample_2;
  assign in_sample[3] = frame_i.sample_3;
  assign in_sample[4] = frame_i.sample_4;
  assign in_sample[5] = frame_i.sample_5;
  assign in_sample[6] = frame_i.sample_6;
  assign in_sample[7] = frame_i.sample_7;

  snga_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (frame_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  snga_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_sample_i    (in_sample),
    .out_sample_o   (out_sample),
    .applied_gain_o (applied_gain),
    .gate_active_o  (gate_active)
  );

  assign frame_i.ready        = in_ready;
  assign frame_o.valid        = out_valid;
  assign frame_o.out_sample_0 = out_sample[0];
  assign frame_o.out_sample_1 = out_sample[1];
  assign frame_o.out_sample_2 = out_sample[2];
  assign frame_o.out_sample_3 = out_sample[3];
  assign frame_o.out_sample_4 = out_sample[4];
  assign frame_o.out_sample_5 = out_sample[5];
  assign frame_o.out_sample_6 = out_sample[6];
  assign frame_o.out_sample_7 = out_sample[7];
  assign frame_o.applied_gain = applied_gain;
  assign frame_o.gate_active  = gate_active;

endmodule

/* hdl/snga_div.sv */
// ----------------------------------------------------------------------------
// Soft noise gate divider
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module snga_div (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [snga_pkg::DivBits-1:0]   dividend_i,
  input  logic [snga_pkg::WideBits-1:0]  divisor_i,
  output logic [snga_pkg::WideBits-1:0]  quotient_o
);

  logic [snga_pkg::WideBits-1:0] rem_q;
  logic [snga_pkg::WideBits-1:0] sh_q;
  logic [snga_pkg::WideBits-1:0] dvs_q;
  logic [snga_pkg::WideBits-1:0] quo_q;
  logic [snga_pkg::WideBits:0]   trial;
  logic [snga_pkg::WideBits:0]   trial_sub;
  logic                          trial_ge;

  assign trial     = {rem_q, sh_q[snga_pkg::WideBits-1]};
  assign trial_ge  = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i[snga_pkg::DivBits-1:snga_pkg::WideBits];
      sh_q  <= dividend_i[snga_pkg::WideBits-1:0];
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (step_i) begin
      rem_q <= trial_ge ? trial_sub[snga_pkg::WideBits-1:0] : trial[snga_pkg::WideBits-1:0];
      sh_q  <= {sh_q[snga_pkg::WideBits-2:0], 1'b0};
      quo_q <= {quo_q[snga_pkg::WideBits-2:0], trial_ge};
    end
  end

  assign quotient_o = quo_q;

endmodule

/* hdl/snga_ctrl.sv */
// ----------------------------------------------------------------------------
// Soft noise gate controller
// Sequences one frame through sum, mean divide, envelope, gain and apply.
// ----------------------------------------------------------------------------
`include "soft_noise_gate_assert.svh"

module snga_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  snga_pkg::snga_sts_t   sts_i,
  output snga_pkg::snga_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_MLOAD,
    S_DIVM,
    S_ENVM,
    S_ENVU,
    S_NUMM,
    S_GEVAL,
    S_DIVG,
    S_GTAKE,
    S_APPLY,
    S_OUT
  } state_e;

  state_e                        state_q, state_d;
  logic [snga_pkg::LoopBits-1:0] cnt_q, cnt_d;
  logic [snga_pkg::LoopBits-1:0] cnt_m1;
  logic                          out_valid_q, out_valid_d;

  assign cnt_m1 = cnt_q - snga_pkg::LoopBits'(1);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cmd_o        = '0;
    cmd_o.mul_op = snga_pkg::MUL_ENV;
    cmd_o.rd_idx = cnt_q[snga_pkg::ChIdxBits-1:0];
    cmd_o.wr_idx = cnt_m1[snga_pkg::ChIdxBits-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.acc_en = 1'b1;
        if (cnt_q == snga_pkg::LoopBits'(snga_pkg::MaxChannels - 1)) begin
          cnt_d   = '0;
          state_d = S_MLOAD;
        end else begin
          cnt_d = cnt_q + snga_pkg::LoopBits'(1);
        end
      end
      S_MLOAD: begin
        cmd_o.div_mean = 1'b1;
        state_d        = S_DIVM;
      end
      S_DIVM: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == snga_pkg::LoopBits'(snga_pkg::WideBits - 1)) begin
          cnt_d   = '0;
          state_d = S_ENVM;
        end else begin
          cnt_d = cnt_q + snga_pkg::LoopBits'(1);
        end
      end
      S_ENVM: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = snga_pkg::MUL_ENV;
        state_d      = S_ENVU;
      end
      S_ENVU: begin
        cmd_o.env_upd = 1'b1;
        state_d       = S_NUMM;
      end
      S_NUMM: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = snga_pkg::MUL_NUM;
        state_d      = S_GEVAL;
      end
      S_GEVAL: begin
        cmd_o.gain_eval = 1'b1;
        cnt_d           = '0;
        state_d         = S_DIVG;
      end
      S_DIVG: begin
        if (!sts_i.need_div) begin
          cnt_d   = '0;
          state_d = S_APPLY;
        end else begin
          cmd_o.div_step = 1'b1;
          if (cnt_q == snga_pkg::LoopBits'(snga_pkg::WideBits - 1)) begin
            cnt_d   = '0;
            state_d = S_GTAKE;
          end else begin
            cnt_d = cnt_q + snga_pkg::LoopBits'(1);
          end
        end
      end
      S_GTAKE: begin
        cmd_o.gain_take = 1'b1;
        cnt_d           = '0;
        state_d         = S_APPLY;
      end
      S_APPLY: begin
        if (cnt_q < snga_pkg::LoopBits'(snga_pkg::MaxChannels)) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_op = snga_pkg::MUL_APP;
        end
        if (cnt_q != '0) begin
          cmd_o.app_wr = 1'b1;
        end
        if (cnt_q == snga_pkg::LoopBits'(snga_pkg::MaxChannels)) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + snga_pkg::LoopBits'(1);
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `SNG_ASSERT_NEXT(a_pending_kept, (state_q == S_OUT) && out_valid_q && !out_ready_i, (state_q == S_OUT) && out_valid_q)
  `SNG_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, (state_q == S_SUM) && (cnt_q == '0))

endmodule

/* hdl/snga_dp.sv */
// ----------------------------------------------------------------------------
// Soft noise gate datapath
// Config registers, frame store, accumulator, shared multiplier, divider,
// envelope and gain registers, output register.
// ----------------------------------------------------------------------------
`include "soft_noise_gate_assert.svh"

module snga_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [snga_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [snga_pkg::RegBits-1:0]           cfg_data_i,
  input  snga_pkg::snga_cmd_t                    cmd_i,
  output snga_pkg::snga_sts_t                    sts_o,
  input  logic signed [snga_pkg::SampleBits-1:0] in_sample_i [snga_pkg::MaxChannels],
  output logic signed [snga_pkg::SampleBits-1:0] out_sample_o [snga_pkg::MaxChannels],
  output logic        [snga_pkg::RegBits-1:0]    applied_gain_o,
  output logic                                   gate_active_o
);

  logic [snga_pkg::CountBits-1:0] active_q;
  logic [snga_pkg::RegBits-1:0]   thresh_q;
  logic [snga_pkg::RegBits-1:0]   ratio_q;
  logic [snga_pkg::RegBits-1:0]   attack_q;
  logic [snga_pkg::RegBits-1:0]   release_q;
  logic [snga_pkg::SampleBits-1:0] level_q, level_d;
  logic                           gated_q;
  logic                           need_div_q;

  logic signed [snga_pkg::SampleBits-1:0] sample_q [snga_pkg::MaxChannels];
  logic signed [snga_pkg::SampleBits-1:0] out_sample_q [snga_pkg::MaxChannels];
  logic [snga_pkg::RegBits-1:0]   out_gain_q;
  logic                           out_gate_q;
  logic [snga_pkg::SumBits-1:0]   sum_q;
  logic signed [snga_pkg::ProdBits-1:0] prod_q;
  logic [snga_pkg::RegBits-1:0]   gain_q;

  logic [snga_pkg::CountBits-1:0] n_eff;
  logic                           rd_active;
  logic                           wr_active;
  logic signed [snga_pkg::SampleBits-1:0] rd_sample;
  logic [snga_pkg::SampleBits-1:0] rd_mag;

  logic [snga_pkg::WideBits-1:0]  level_w;
  logic [snga_pkg::WideBits-1:0]  thr_w;
  logic [snga_pkg::WideBits-1:0]  quotient;
  logic [snga_pkg::RegBits-1:0]   coeff;

  logic signed [snga_pkg::MulABits-1:0] mul_a;
  logic signed [snga_pkg::MulBBits-1:0] mul_b;
  logic signed [snga_pkg::ProdBits-1:0] prod_d;

  logic signed [snga_pkg::ProdBits-1:0] lvl_ext;
  logic signed [snga_pkg::ProdBits-1:0] env_next;

  logic signed [snga_pkg::NumBits-1:0] prod_ext;
  logic signed [snga_pkg::NumBits-1:0] thr_term;
  logic signed [snga_pkg::NumBits-1:0] num;
  logic                           num_pos;
  logic                           gated_now;
  logic [snga_pkg::DivBits-1:0]   gain_dvd;
  logic [snga_pkg::DivBits-1:0]   sat_lim;
  logic                           gain_sat;
  logic                           div_gain;

  logic                           div_load;
  logic [snga_pkg::DivBits-1:0]   div_dvd;
  logic [snga_pkg::WideBits-1:0]  div_dvs;

  logic signed [snga_pkg::ProdBits-1:0] rnd;
  logic signed [snga_pkg::ProdBits-1:0] shifted;
  logic                           fits;
  logic [snga_pkg::SampleBits-1:0] sat_val;

  always_comb begin
    priority if (active_q == '0) begin
      n_eff = snga_pkg::CountBits'(1);
    end else if (active_q > snga_pkg::CountBits'(snga_pkg::MaxChannels)) begin
      n_eff = snga_pkg::CountBits'(snga_pkg::MaxChannels);
    end else begin
      n_eff = active_q;
    end
  end

  assign rd_sample = sample_q[cmd_i.rd_idx];
  assign rd_active = snga_pkg::CountBits'(cmd_i.rd_idx) < n_eff;
  assign wr_active = snga_pkg::CountBits'(cmd_i.wr_idx) < n_eff;
  assign rd_mag    = rd_sample[snga_pkg::SampleBits-1]
                   ? (~rd_sample + snga_pkg::SampleBits'(1)) : rd_sample;

  assign level_w = snga_pkg::WideBits'(level_q);
  assign thr_w   = snga_pkg::WideBits'(thresh_q);
  assign coeff   = (quotient > level_w) ? attack_q : release_q;

  always_comb begin
    unique case (cmd_i.mul_op)
      snga_pkg::MUL_ENV: begin
        mul_a = {1'b0, quotient} - {1'b0, level_w};
        mul_b = {1'b0, coeff};
      end
      snga_pkg::MUL_NUM: begin
        mul_a = {1'b0, level_w} - {1'b0, thr_w};
        mul_b = {1'b0, ratio_q};
      end
      snga_pkg::MUL_APP: begin
        mul_a = {{(snga_pkg::MulABits - snga_pkg::SampleBits){rd_sample[snga_pkg::SampleBits-1]}},
                 rd_sample};
        mul_b = {1'b0, gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign lvl_ext  = snga_pkg::ProdBits'(level_w);
  assign env_next = lvl_ext + (prod_q >>> snga_pkg::CoeffFrac);
  assign level_d  = env_next[snga_pkg::ProdBits-1] ? '0 : env_next[snga_pkg::SampleBits-1:0];

  assign prod_ext  = {prod_q[snga_pkg::ProdBits-1], prod_q};
  assign thr_term  = snga_pkg::NumBits'({thresh_q, {snga_pkg::RatioFrac{1'b0}}});
  assign num       = prod_ext + thr_term;
  assign num_pos   = !num[snga_pkg::NumBits-1] && (num != '0);
  assign gated_now = (level_q != '0) && (level_w < thr_w);
  assign gain_dvd  = snga_pkg::DivBits'({num[snga_pkg::GainNumBits-1:0],
                                         {snga_pkg::GainShift{1'b0}}});
  assign sat_lim   = snga_pkg::DivBits'({level_w[snga_pkg::RegBits-1:0],
                                         {snga_pkg::RegBits{1'b0}}});
  assign gain_sat  = gain_dvd >= sat_lim;
  assign div_gain  = gated_now && num_pos && !gain_sat;

  assign div_load = cmd_i.div_mean | (cmd_i.gain_eval & div_gain);
  assign div_dvd  = cmd_i.div_mean ? snga_pkg::DivBits'(sum_q) : gain_dvd;
  assign div_dvs  = cmd_i.div_mean ? snga_pkg::WideBits'(n_eff) : level_w;

  snga_div u_div (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (quotient)
  );

  assign rnd     = prod_q + (prod_q[snga_pkg::ProdBits-1] ? snga_pkg::RndBias : '0);
  assign shifted = rnd >>> snga_pkg::GainFrac;
  assign fits    = (&shifted[snga_pkg::ProdBits-1:snga_pkg::SampleBits-1])
                 | ~(|shifted[snga_pkg::ProdBits-1:snga_pkg::SampleBits-1]);
  assign sat_val = fits ? shifted[snga_pkg::SampleBits-1:0]
                 : (shifted[snga_pkg::ProdBits-1]
                    ? {1'b1, {(snga_pkg::SampleBits-1){1'b0}}}
                    : {1'b0, {(snga_pkg::SampleBits-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= snga_pkg::ActiveReset;
      thresh_q   <= snga_pkg::GainUnity;
      ratio_q    <= snga_pkg::RatioUnity;
      attack_q   <= '0;
      release_q  <= '0;
      level_q    <= '0;
      gated_q    <= 1'b0;
      need_div_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (snga_pkg::cfg_idx_e'(cfg_idx_i))
          snga_pkg::CFG_ACTIVE:  active_q  <= cfg_data_i[snga_pkg::CountBits-1:0];
          snga_pkg::CFG_THRESH:  thresh_q  <= cfg_data_i;
          snga_pkg::CFG_RATIO:   ratio_q   <= cfg_data_i;
          snga_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i;
          snga_pkg::CFG_RELEASE: release_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.env_upd) begin
        level_q <= level_d;
      end
      if (cmd_i.gain_eval) begin
        gated_q    <= gated_now;
        need_div_q <= div_gain;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_sample_i;
    end else if (cmd_i.app_wr && gated_q && wr_active) begin
      sample_q[cmd_i.wr_idx] <= sat_val;
    end
    if (cmd_i.load) begin
      sum_q <= '0;
    end else if (cmd_i.acc_en && rd_active) begin
      sum_q <= sum_q + snga_pkg::SumBits'(rd_mag);
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.gain_eval) begin
      priority if (!gated_now) begin
        gain_q <= snga_pkg::GainUnity;
      end else if (!num_pos) begin
        gain_q <= '0;
      end else if (gain_sat) begin
        gain_q <= snga_pkg::GainMax;
      end else begin
      end
    end else if (cmd_i.gain_take) begin
      gain_q <= quotient[snga_pkg::RegBits-1:0];
    end
    if (cmd_i.out_load) begin
      out_sample_q <= sample_q;
      out_gain_q   <= gain_q;
      out_gate_q   <= gated_q;
    end
  end

  assign sts_o.need_div = need_div_q;
  assign out_sample_o   = out_sample_q;
  assign applied_gain_o = out_gain_q;
  assign gate_active_o  = out_gate_q;

  `SNG_ASSERT_NEXT(a_env_bounded, cmd_i.env_upd, (level_q <= $past(level_q)) || (level_q <= $past(quotient)))
  `SNG_ASSERT_NEXT(a_open_unity, cmd_i.gain_eval && !gated_now, !gated_q && (gain_q == snga_pkg::GainUnity))

endmodule
